>>> hw/rtl/sldf_pkg.sv
// Shared constants and types for the sync/length/checksum deframer.
// No dependencies.
`default_nettype none

package sldf_pkg;

   // Frame layout
   localparam logic [7:0]  SYNC_BYTE         = 8'hAA;
   localparam int          POS_W             = 17;
   localparam int          LEN_W             = 16;
   localparam logic [POS_W-1:0] POS_HUNT     = 17'd0;
   localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd1;
   localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd2;
   localparam logic [POS_W-1:0] POS_PAYLOAD0 = 17'd3;

   // Byte roles
   localparam logic [1:0] ROLE_DROP    = 2'd0;
   localparam logic [1:0] ROLE_HEADER  = 2'd1;
   localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
   localparam logic [1:0] ROLE_CHECK   = 2'd3;

   // One result item
   typedef struct packed {
      logic [1:0]       byte_role;
      logic [POS_W-1:0] byte_position;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       event_code;
      logic             frame_end;
      logic             checksum_good;
      logic             too_short;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/sldf_parse.sv
// Frame state (position, length, running sum, event code) and per-byte
// classification. Depends on sldf_pkg.
`default_nettype none

module sldf_parse
   import sldf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output result_type      result
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       event_ff, event_in;
   logic [POS_W-1:0] payload_end;
   logic [7:0]       total;

   assign payload_end = {1'b0, len_ff} + POS_PAYLOAD0;
   assign total       = sum_ff + rx_byte;

   // Classify the byte and work out the next frame state
   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      event_in = event_ff;
      result   = '0;
      result.byte_position = pos_ff;
      result.data_byte     = rx_byte;
      if (pos_ff == POS_HUNT) begin
         if (rx_byte == SYNC_BYTE) begin
            result.byte_role = ROLE_HEADER;
            pos_in           = POS_LEN_HI;
         end else begin
            result.byte_role = ROLE_DROP;
         end
         result.payload_length = len_ff;
         result.event_code     = event_ff;
      end else if (pos_ff == POS_LEN_HI) begin
         len_in                = {rx_byte, 8'h00};
         sum_in                = rx_byte;
         pos_in                = POS_LEN_LO;
         result.byte_role      = ROLE_HEADER;
         result.payload_length = len_in;
         result.event_code     = event_ff;
      end else if (pos_ff == POS_LEN_LO) begin
         len_in                = {len_ff[15:8], rx_byte};
         sum_in                = total;
         pos_in                = POS_PAYLOAD0;
         result.byte_role      = ROLE_HEADER;
         result.payload_length = len_in;
         result.event_code     = event_ff;
      end else if (pos_ff < payload_end) begin
         if (pos_ff == POS_PAYLOAD0) begin
            event_in = rx_byte;
         end
         sum_in                = total;
         pos_in                = pos_ff + 17'd1;
         result.byte_role      = ROLE_PAYLOAD;
         result.payload_length = len_ff;
         result.event_code     = event_in;
      end else begin
         // checksum byte: close the frame and go back to hunting
         result.byte_role      = ROLE_CHECK;
         result.frame_end      = 1'b1;
         result.checksum_good  = (total == 8'h00);
         result.too_short      = (len_ff == '0);
         result.payload_length = len_ff;
         result.event_code     = event_ff;
         pos_in   = POS_HUNT;
         len_in   = '0;
         sum_in   = '0;
         event_in = '0;
      end
   end

   // State registers advance once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HUNT;
         len_ff   <= '0;
         sum_ff   <= '0;
         event_ff <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         event_ff <= event_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/sync_length_checksum_deframer.sv
// An accepted req goes through the input register, then the result register.
// Throughput: one item per cycle; a new item is taken every cycle while the
// result register drains or is empty.
// Reset (synchronous, active high) empties both registers and returns the
// parser to hunting for sync. Depends on sldf_pkg and sldf_parse.
`default_nettype none

module sync_length_checksum_deframer
   import sldf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_byte_role,
   output logic [POS_W-1:0]      rsp_byte_position,
   output logic [7:0]            rsp_data_byte,
   output logic [LEN_W-1:0]      rsp_payload_length,
   output logic [7:0]            rsp_event_code,
   output logic                  rsp_frame_end,
   output logic                  rsp_checksum_good,
   output logic                  rsp_too_short
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   logic       out_adv;
   logic       step;
   logic       req_fire;

   // Pipeline flow control
   assign out_adv   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_adv;
   assign req_ready = !in_valid_ff || out_adv;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sldf_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_role      = out_ff.byte_role;
   assign rsp_byte_position  = out_ff.byte_position;
   assign rsp_data_byte      = out_ff.data_byte;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_event_code     = out_ff.event_code;
   assign rsp_frame_end      = out_ff.frame_end;
   assign rsp_checksum_good  = out_ff.checksum_good;
   assign rsp_too_short      = out_ff.too_short;

   // Frame end only ever comes with the checksum role
   a_end_role: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> (rsp_byte_role == ROLE_CHECK))
      else $error("frame_end on a non-checksum item");

   // Dropped bytes sit at position zero and never close a frame
   a_drop_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_role == ROLE_DROP) |-> (rsp_byte_position == '0 && !rsp_frame_end))
      else $error("dropped item with nonzero position or frame_end");

   // Status flags only at frame end
   a_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_end) |-> (!rsp_checksum_good && !rsp_too_short))
      else $error("status flag outside frame end");

endmodule

`default_nettype wire
